// ===== src/irn_pkg.sv =====
`timescale 1ns / 1ps

package irn_pkg;

  // Intensity format: signed fixed point, 20 bits, FracBits fraction bits
  localparam int InWidth  = 20;
  localparam int FracBits = 4;
  localparam int PixBits  = 8;
  localparam int PixMax   = 255;

  // Pass-through test limit: 255 in intensity units
  localparam int PassLimit = PixMax << FracBits;

  // Queue between front and back
  localparam int QDepth = 4;
  localparam int QAw    = $clog2(QDepth);

  // Divider: one quotient bit per step
  localparam int DivSteps = PixBits;
  localparam int CntW     = $clog2(DivSteps);
  localparam int ProdW    = InWidth + PixBits;

  // Most negative / most positive intensity
  localparam logic signed [InWidth-1:0] IntMin = {1'b1, {(InWidth-1){1'b0}}};
  localparam logic signed [InWidth-1:0] IntMax = {1'b0, {(InWidth-1){1'b1}}};

  // How the back end finishes an item
  typedef enum logic {
    KIND_DIRECT = 1'b0,
    KIND_DIVIDE = 1'b1
  } kind_t;

  // One queued convert item
  typedef struct packed {
    kind_t                kind;
    logic [PixBits-1:0]   pixel;
    logic                 passed;
    logic [InWidth-1:0]   num;
    logic [InWidth-1:0]   den;
  } entry_t;

endpackage

// ===== src/irn_front.sv =====
`timescale 1ns / 1ps

module irn_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_req_type,
  input  logic                               in_frame_start,
  input  logic signed [irn_pkg::InWidth-1:0] in_intensity,
  input  logic                               q_full,
  output logic                               q_push,
  output irn_pkg::entry_t                    q_entry
);

  logic signed [irn_pkg::InWidth-1:0] max_r;
  logic signed [irn_pkg::InWidth-1:0] min_r;
  logic                               scan_acc;

  logic signed [irn_pkg::InWidth:0]   num_w;
  logic signed [irn_pkg::InWidth:0]   den_w;

  // Scans never wait; converts wait for queue space
  assign in_ready = !in_req_type || !q_full;
  assign scan_acc = in_valid && !in_req_type;
  assign q_push   = in_valid && in_req_type && !q_full;

  // Running min/max
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= irn_pkg::IntMin;
      min_r <= irn_pkg::IntMax;
    end else if (scan_acc) begin
      if (in_frame_start) begin
        max_r <= in_intensity;
        min_r <= in_intensity;
      end else begin
        if (in_intensity > max_r) max_r <= in_intensity;
        if (in_intensity < min_r) min_r <= in_intensity;
      end
    end
  end

  assign num_w = {in_intensity[irn_pkg::InWidth-1], in_intensity}
               - {min_r[irn_pkg::InWidth-1], min_r};
  assign den_w = {max_r[irn_pkg::InWidth-1], max_r}
               - {min_r[irn_pkg::InWidth-1], min_r};

  // Classify a convert item against the current range
  always_comb begin
    int fl;
    fl = int'(in_intensity) >>> irn_pkg::FracBits;
    q_entry        = '0;
    q_entry.kind   = irn_pkg::KIND_DIRECT;
    q_entry.num    = num_w[irn_pkg::InWidth-1:0];
    q_entry.den    = den_w[irn_pkg::InWidth-1:0];
    if ((int'(max_r) <= irn_pkg::PassLimit) && !min_r[irn_pkg::InWidth-1]) begin
      // range already within pixel range: floor and clamp
      q_entry.passed = 1'b1;
      if (in_intensity[irn_pkg::InWidth-1]) begin
        q_entry.pixel = '0;
      end else if (fl > irn_pkg::PixMax) begin
        q_entry.pixel = irn_pkg::PixBits'(irn_pkg::PixMax);
      end else begin
        q_entry.pixel = fl[irn_pkg::PixBits-1:0];
      end
    end else if (max_r <= min_r) begin
      // flat frame
      q_entry.pixel = '0;
    end else if (num_w <= 0) begin
      q_entry.pixel = '0;
    end else if (num_w >= den_w) begin
      q_entry.pixel = irn_pkg::PixBits'(irn_pkg::PixMax);
    end else begin
      // 0 < num < den: quotient fits below 255
      q_entry.kind = irn_pkg::KIND_DIVIDE;
    end
  end

endmodule

// ===== src/irn_queue.sv =====
`timescale 1ns / 1ps

module irn_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  irn_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output irn_pkg::entry_t head
);

  irn_pkg::entry_t             mem_r [irn_pkg::QDepth];
  logic [irn_pkg::QAw-1:0]     wr_r;
  logic [irn_pkg::QAw-1:0]     rd_r;
  logic [irn_pkg::QAw:0]       cnt_r;

  assign full      = (cnt_r == (irn_pkg::QAw+1)'(irn_pkg::QDepth));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rd_r];

  // Storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_entry;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop)  rd_r <= rd_r + 1'b1;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ===== src/irn_back.sv =====
`timescale 1ns / 1ps

module irn_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_not_empty,
  input  irn_pkg::entry_t             q_head,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [irn_pkg::PixBits-1:0] out_pixel_out,
  output logic                        out_passed_through
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_HOLD
  } state_t;

  state_t                          state_r;
  logic                            out_valid_r;
  logic [irn_pkg::PixBits-1:0]     pixel_r;
  logic                            passed_r;
  logic [irn_pkg::InWidth-1:0]     rem_r;
  logic [irn_pkg::PixBits-1:0]     dvd_r;
  logic [irn_pkg::InWidth-1:0]     den_r;
  logic [irn_pkg::PixBits-1:0]     quo_r;
  logic [irn_pkg::CntW-1:0]        cnt_r;

  logic                            out_free;
  logic                            load_out;
  logic [irn_pkg::ProdW-1:0]       prod;
  logic [irn_pkg::InWidth:0]       trial;
  logic [irn_pkg::InWidth:0]       diff;
  logic                            ge;

  assign out_free = !out_valid_r || out_ready;
  assign q_pop    = (state_r == S_IDLE) && q_not_empty && out_free;

  // A new item enters the output register: direct pop or finished division
  assign load_out = (q_pop && (q_head.kind == irn_pkg::KIND_DIRECT))
                  || ((state_r == S_HOLD) && out_free);

  // num * 255 as a shift and subtract
  assign prod = ({q_head.num, {irn_pkg::PixBits{1'b0}}})
              - irn_pkg::ProdW'(q_head.num);

  // One restoring division step; remainder stays below den
  assign trial = {rem_r, dvd_r[irn_pkg::PixBits-1]};
  assign ge    = (trial >= {1'b0, den_r});
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (load_out) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (q_pop) begin
            if (q_head.kind == irn_pkg::KIND_DIRECT) begin
              pixel_r     <= q_head.pixel;
              passed_r    <= q_head.passed;
            end else begin
              // remainder starts with the high part, which is below den
              rem_r   <= prod[irn_pkg::ProdW-1:irn_pkg::PixBits];
              dvd_r   <= prod[irn_pkg::PixBits-1:0];
              den_r   <= q_head.den;
              cnt_r   <= '0;
              state_r <= S_DIV;
            end
          end
        end
        S_DIV: begin
          rem_r <= ge ? diff[irn_pkg::InWidth-1:0] : trial[irn_pkg::InWidth-1:0];
          dvd_r <= {dvd_r[irn_pkg::PixBits-2:0], 1'b0};
          quo_r <= {quo_r[irn_pkg::PixBits-2:0], ge};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == irn_pkg::CntW'(irn_pkg::DivSteps - 1)) state_r <= S_HOLD;
        end
        S_HOLD: begin
          if (out_free) begin
            pixel_r     <= quo_r;
            passed_r    <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_pixel_out      = pixel_r;
  assign out_passed_through = passed_r;

endmodule

// ===== src/intensity_range_normalizer_8bit.sv =====
`timescale 1ns / 1ps

// Min/max normalization of a frame to 8-bit pixels. Stream the frame once as
// scan items (req_type 0, frame_start on the first) to track min and max; scan
// items give no result and are taken every cycle. Then stream it again as
// convert items (req_type 1), each giving one pixel. A convert item is
// classified on entry against the current range and placed in a 4-entry
// queue; pass-through, flat-range and clamped items go straight to the output
// register, while an item needing 255*(x-min)/(max-min) is loaded into the
// bit-serial divider, runs 8 quotient steps and holds until the output is free.
// Direct items go out at 1 item per cycle while the divider is idle and the
// consumer is ready; the divider takes no new item until its quotient is out.
// Scans and converts are still taken meanwhile; the result sits in an output
// register, so a stalled consumer does not block the front till the queue fills.
module intensity_range_normalizer_8bit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_req_type,
  input  logic                               in_frame_start,
  input  logic signed [irn_pkg::InWidth-1:0] in_intensity,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [irn_pkg::PixBits-1:0]        out_pixel_out,
  output logic                               out_passed_through
);

  logic            q_full;
  logic            q_push;
  logic            q_pop;
  logic            q_not_empty;
  irn_pkg::entry_t q_entry;
  irn_pkg::entry_t q_head;

  // Front: min/max tracking and classification
  irn_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_frame_start (in_frame_start),
    .in_intensity   (in_intensity),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_entry        (q_entry)
  );

  // Queue of classified convert items
  irn_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  // Back: divider and output register
  irn_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_not_empty        (q_not_empty),
    .q_head             (q_head),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_pixel_out      (out_pixel_out),
    .out_passed_through (out_passed_through)
  );

endmodule
